// ===== design/dqs_pkg.sv =====
`default_nettype none

package dqs_pkg;

  // Operation codes on the request channel
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  // Response status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  // Broadcast shift command for the cell row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,   // take the left neighbor (toward the back)
    CELL_SHL    // take the right neighbor (toward the front)
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      wr;    // direct load, overrides the shift
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/dqs_req_if.sv =====
`default_nettype none

interface dqs_req_if
  import dqs_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  word_t      value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ===== design/dqs_rsp_if.sv =====
`default_nettype none

interface dqs_rsp_if
  import dqs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  word_t            result_value;
  logic [POS_W-1:0] position;
  logic             last;

  modport source (output valid, output status, output result_value, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input result_value, input position,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== design/dqs_cell.sv =====
`default_nettype none

module dqs_cell
  import dqs_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire word_t      load_data,
  input  wire word_t      left_data,
  input  wire word_t      right_data,
  output word_t           data
);

  // One storage slot of the row; shifts with its neighbors
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      data <= load_data;
    end else begin
      case (ctrl.cmd)
        CELL_SHR: data <= left_data;
        CELL_SHL: data <= right_data;
        default:  data <= data;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/deque_with_search.sv =====
// Bounded double-ended queue of signed 32-bit values with front-first search.
//
// Channels: req carries op and value, rsp carries status, result_value,
// position and last; both use a valid/ready transfer.
// Storage is a row of DEPTH cells; cell 0 holds the front element when idle.
// Push front shifts the row toward the back, pop front shifts it toward the
// front, push back loads the cell at the current count, pop back reads the
// cell at count minus one.
// For push and pop the response is registered and shows up in the cycle
// after the request transfer. Search and dump rotate the whole row through
// cell 0, one cell per cycle unless a step with a response waits on a stalled
// receiver; dump returns one transfer per stored element.
// A new request is taken only once the row is back in place and the
// response register is free or being drained in the same cycle.
// Reset empties the queue and drops any pending response; cell contents are
// not cleared. A stalled receiver holds the response and freezes the walk
// at a step that has a response to give.
`default_nettype none

module deque_with_search
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dqs_req_if.sink    req,
  dqs_rsp_if.source  rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL      = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] step;
  logic             is_dump;
  logic             found;
  word_t            key;

  word_t            cell_q [DEPTH];
  cell_ctrl_t       ctrl   [DEPTH];

  logic             accept;
  logic             out_free;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] step_p1;
  logic             in_range;
  word_t            head;
  word_t            tail;

  cell_cmd_t        cmd;
  logic             push_back_wr;
  logic             emit;
  logic [1:0]       emit_status;
  word_t            emit_val;
  logic [POS_W-1:0] emit_pos;
  logic             emit_last;
  logic             walk_emit;
  logic             advance;

  assign accept    = req.valid & req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign full      = (count == FULL);
  assign empty     = (count == '0);
  assign cnt_m1    = count - CNT_W'(1);
  assign step_p1   = CNT_W'(step) + CNT_W'(1);
  assign in_range  = CNT_W'(step) < count;
  assign head      = cell_q[0];
  assign tail      = cell_q[cnt_m1[IDX_W-1:0]];

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].cmd = cmd;
    assign ctrl[i].wr  = push_back_wr && (count == CNT_W'(i));

    dqs_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .load_data  (req.value),
      .left_data  ((i == 0) ? req.value : cell_q[(i + DEPTH - 1) % DEPTH]),
      .right_data (cell_q[(i + 1) % DEPTH]),
      .data       (cell_q[i])
    );
  end

  // Walk step: cell 0 holds element number step
  always_comb begin
    walk_emit = 1'b0;
    if (state == S_WALK && in_range) begin
      if (is_dump) begin
        walk_emit = 1'b1;
      end else if (!found) begin
        walk_emit = (head == key) || (step_p1 == count);
      end
    end
  end

  assign advance = (state == S_WALK) && (!walk_emit || out_free);

  // Row command and response source
  always_comb begin
    cmd          = CELL_HOLD;
    push_back_wr = 1'b0;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_val     = '0;
    emit_pos     = '0;
    emit_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.op)
            OP_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) emit_status = ST_OVERFLOW;
              else      cmd = CELL_SHR;
            end
            OP_PUSH_BACK: begin
              emit = 1'b1;
              if (full) emit_status = ST_OVERFLOW;
              else      push_back_wr = 1'b1;
            end
            OP_POP_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = ST_EMPTY;
              end else begin
                emit_val = head;
                cmd      = CELL_SHL;
              end
            end
            OP_POP_BACK: begin
              emit = 1'b1;
              if (empty) emit_status = ST_EMPTY;
              else       emit_val = tail;
            end
            OP_SEARCH, OP_DUMP: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (advance) begin
          cmd  = CELL_SHL;
          emit = walk_emit;
        end
        if (is_dump) begin
          emit_val  = head;
          emit_pos  = POS_W'(step_p1);
          emit_last = (step_p1 == count);
        end else if (head == key) begin
          emit_val = head;
          emit_pos = POS_W'(step_p1);
        end else begin
          emit_status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  // Control state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      is_dump   <= 1'b0;
      found     <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.op)
              OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (!full) count <= count + CNT_W'(1);
              end
              OP_POP_FRONT, OP_POP_BACK: begin
                if (!empty) count <= cnt_m1;
              end
              OP_SEARCH, OP_DUMP: begin
                if (!empty) begin
                  state   <= S_WALK;
                  step    <= '0;
                  found   <= 1'b0;
                  is_dump <= (req.op == OP_DUMP);
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (advance) begin
            step <= step + IDX_W'(1);
            if (walk_emit) found <= 1'b1;
            if (step == LAST_STEP) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (emit)           rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.status       <= emit_status;
      rsp.result_value <= emit_val;
      rsp.position     <= emit_pos;
      rsp.last         <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) key <= req.value;
  end

endmodule

`default_nettype wire

// ===== design/dqs_chk.sv =====
`default_nettype none

module dqs_chk
  import dqs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic [1:0]       rsp_status,
  input wire logic [POS_W-1:0] rsp_position,
  input wire logic             rsp_last
);

  // A stalled response stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // Error statuses end the request and carry no position
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_OVERFLOW || rsp_status == ST_EMPTY ||
                  rsp_status == ST_NOTFOUND) |-> rsp_last && rsp_position == '0)
    else $error("error status with position or without last");

  // Nothing is pending right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response pending after reset");

  // A response that is not the last one comes from a dump walk
  a_multi_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == ST_OK && rsp_position != '0)
    else $error("non-final response without position");

endmodule

bind deque_with_search dqs_chk u_dqs_chk (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.position),
  .rsp_last     (rsp.last)
);

`default_nettype wire
